// ===== sv/bla_pkg.sv =====
// Shared types, codes and field widths for the bounded list array engine.
package bla_pkg;

	localparam int OP_W    = 3;
	localparam int POS_W   = 6;
	localparam int ITEM_W  = 32;
	localparam int ST_W    = 3;
	localparam int CNT_W   = 7;
	localparam int CAP_W   = 7;
	localparam int CFG_A_W = 1;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;
	localparam logic [CAP_W-1:0] CAPACITY_RST = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_READ      = 3'd0,
		OP_INS_FRONT = 3'd1,
		OP_INS_BACK  = 3'd2,
		OP_INS_AT    = 3'd3,
		OP_DELETE    = 3'd4,
		OP_SEARCH    = 3'd5,
		OP_OVERWRITE = 3'd6
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_BADPOS   = 3'd1,
		ST_FULL     = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [CFG_A_W-1:0] {
		REG_CAPACITY     = 1'b0,
		REG_INVALID_READ = 1'b1
	} reg_idx_t;

	// What every slot cell does at each clock edge.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_UP,
		CELL_DOWN,
		CELL_ROT
	} cell_cmd_t;

endpackage

// ===== sv/bla_cell.sv =====
// One slot of the list: picks its next value from itself, a neighbor or the new item.
module bla_cell
	import bla_pkg::*;
#(
	parameter int DW  = DATA_WIDTH_DEF,
	parameter int AW  = 6,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  cell_cmd_t     cmd,
	input  logic [AW-1:0] pos,
	input  logic [DW-1:0] din,
	input  logic [DW-1:0] prv,
	input  logic [DW-1:0] nxt,
	output logic [DW-1:0] dout
);

	localparam logic [AW-1:0] MY_IDX = AW'(IDX);

	logic [DW-1:0] data_q;
	logic [DW-1:0] data_d;

	always_comb begin
		data_d = data_q;
		unique case (cmd)
			CELL_HOLD: data_d = data_q;
			CELL_LOAD: if (MY_IDX == pos) data_d = din;
			CELL_UP: begin
				if (MY_IDX > pos) data_d = prv;
				else if (MY_IDX == pos) data_d = din;
			end
			CELL_DOWN: if (MY_IDX >= pos) data_d = nxt;
			CELL_ROT: data_d = nxt;
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign dout = data_q;

endmodule

// ===== sv/bla_chain.sv =====
// Row of slot cells linked to neighbors; cell 0 is its own prv, the last wraps to head.
module bla_chain
	import bla_pkg::*;
#(
	parameter int DW    = DATA_WIDTH_DEF,
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  cell_cmd_t     cmd,
	input  logic [AW-1:0] pos,
	input  logic [DW-1:0] din,
	output logic [DW-1:0] head
);

	logic [DW-1:0] slot_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DW-1:0] prv;
		logic [DW-1:0] nxt;

		if (i == 0) begin : g_first
			assign prv = slot_data[0];
		end else begin : g_mid
			assign prv = slot_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign nxt = slot_data[0];
		end else begin : g_inner
			assign nxt = slot_data[i+1];
		end

		bla_cell #(
			.DW  (DW),
			.AW  (AW),
			.IDX (i)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.pos  (pos),
			.din  (din),
			.prv  (prv),
			.nxt  (nxt),
			.dout (slot_data[i])
		);
	end

	assign head = slot_data[0];

endmodule

// ===== sv/bounded_list_array_engine_top.sv =====
// Top level of the bounded list array engine: request decode, scan sequencer and result register.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: op; tdata: position, item
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: value, found_index, count,
//                                    full_res, empty_res
// cfg_*     in   cfg_we             cfg_index selects the register, cfg_data holds it
//
// Inserts, deletes, overwrites and every request that fails its checks finish in the
// cycle they are accepted, so they can follow each other in every cycle while results are taken.
// A read of a valid position or a search on a non-empty list starts a scan: the cell row rotates
// DEPTH times past the head, which is compared once per cycle, and is back in order after.
// Reset clears the count and invalid-read value and sets capacity to 64; slots keep their data.
// A result waiting on m_tready blocks new requests until it is taken or leaves this cycle.
module bounded_list_array_engine_top
	import bla_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// tuser: op[2:0]
	input  logic [OP_W-1:0]    s_tuser,
	// tdata: position[5:0], item[37:6], zero fill [39:38]
	input  logic [39:0]        s_tdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	// tuser: status[2:0]
	output logic [ST_W-1:0]    m_tuser,
	// tdata: value[31:0], found_index[37:32], count[44:38], full_res[45], empty_res[46],
	// zero fill [47]
	output logic [47:0]        m_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  logic               cfg_we,
	input  logic [CFG_A_W-1:0] cfg_index,
	input  logic [ITEM_W-1:0]  cfg_data
);

	localparam int DW = DATA_WIDTH;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > CNT_W) ? CW : CNT_W;
	localparam int WW = (DW > ITEM_W) ? DW : ITEM_W;
	localparam logic [AW-1:0] LAST_STEP = AW'(DEPTH - 1);
	localparam logic [MW-1:0] DEPTH_M   = MW'(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_HOLD
	} state_t;

	state_t             state_q;
	logic [CAP_W-1:0]   cap_q;
	logic [ITEM_W-1:0]  inv_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      step_q;
	op_t                op_q;
	logic [POS_W-1:0]   pos_q;
	logic [DW-1:0]      key_q;
	logic               hit_q;
	logic [AW-1:0]      hit_idx_q;
	logic [DW-1:0]      rd_val_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic [ITEM_W-1:0]  out_value_q;
	logic [POS_W-1:0]   out_idx_q;
	logic [CNT_W-1:0]   out_count_q;
	logic               out_full_q;
	logic               out_empty_q;

	op_t                in_op;
	logic [POS_W-1:0]   in_pos;
	logic [ITEM_W-1:0]  in_item;
	logic [WW-1:0]      item_ext;
	logic [DW-1:0]      item_d;
	logic [DW-1:0]      head;

	logic [MW-1:0]      cnt_m;
	logic [MW-1:0]      pos_m;
	logic [MW-1:0]      cap_m;
	logic [MW-1:0]      cap_eff;
	logic [MW-1:0]      step_m;
	logic               out_free;
	logic               accept;

	cell_cmd_t          cell_cmd;
	logic [AW-1:0]      cell_pos;
	logic [MW-1:0]      ins_pos;
	logic               do_ins;
	logic               start_scan;
	logic               imm_done;
	status_t            imm_status;
	logic [CW-1:0]      count_nxt;

	logic               hit_nxt;
	logic [AW-1:0]      hit_idx_nxt;
	logic [DW-1:0]      rd_val_nxt;
	logic               scan_last;

	logic               load_out;
	status_t            res_status;
	logic [DW-1:0]      res_data;
	logic               res_use_data;
	logic [AW-1:0]      res_idx;
	logic [CW-1:0]      res_count;
	logic [MW-1:0]      res_count_m;
	logic [MW-1:0]      res_idx_m;
	logic [WW-1:0]      res_data_ext;

	// ---------------------------------------------------------------- fields
	assign in_op    = op_t'(s_tuser);
	assign in_pos   = s_tdata[POS_W-1:0];
	assign in_item  = s_tdata[POS_W+ITEM_W-1:POS_W];
	assign item_ext = WW'(in_item);
	assign item_d   = item_ext[DW-1:0];

	assign cnt_m   = MW'(count_q);
	assign pos_m   = MW'(in_pos);
	assign cap_m   = MW'(cap_q);
	assign cap_eff = (cap_m > DEPTH_M) ? DEPTH_M : cap_m;
	assign step_m  = MW'(step_q);

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	// ------------------------------------------------------- request decode
	always_comb begin
		cell_cmd   = (state_q == S_SCAN) ? CELL_ROT : CELL_HOLD;
		cell_pos   = '0;
		ins_pos    = '0;
		do_ins     = 1'b0;
		start_scan = 1'b0;
		imm_status = ST_OK;
		count_nxt  = count_q;

		if (accept) begin
			unique case (in_op)
				OP_READ: begin
					if (pos_m >= cnt_m) imm_status = ST_BADPOS;
					else start_scan = 1'b1;
				end
				OP_SEARCH: begin
					if (count_q == '0) imm_status = ST_NOTFOUND;
					else start_scan = 1'b1;
				end
				OP_INS_FRONT: do_ins = 1'b1;
				OP_INS_BACK: begin
					do_ins  = 1'b1;
					ins_pos = cnt_m;
				end
				OP_INS_AT: begin
					if (pos_m > cnt_m) begin
						imm_status = ST_BADPOS;
					end else begin
						do_ins  = 1'b1;
						ins_pos = pos_m;
					end
				end
				OP_DELETE: begin
					if (pos_m > cnt_m) imm_status = ST_BADPOS;
					else if (count_q == '0) imm_status = ST_EMPTY;
					else if (pos_m == cnt_m) imm_status = ST_BADPOS;
					else begin
						cell_cmd  = CELL_DOWN;
						cell_pos  = pos_m[AW-1:0];
						count_nxt = count_q - 1'b1;
					end
				end
				OP_OVERWRITE: begin
					if (pos_m >= cnt_m) begin
						imm_status = ST_BADPOS;
					end else begin
						cell_cmd = CELL_LOAD;
						cell_pos = pos_m[AW-1:0];
					end
				end
				default: imm_status = ST_OK;
			endcase

			if (do_ins) begin
				if (cnt_m >= cap_eff) begin
					imm_status = ST_FULL;
				end else begin
					// Below capacity the insert point is below DEPTH, so it fits the cell index.
					cell_cmd  = CELL_UP;
					cell_pos  = ins_pos[AW-1:0];
					count_nxt = count_q + 1'b1;
				end
			end
		end
	end

	assign imm_done = accept && !start_scan;

	// ------------------------------------------------------- scan compare
	always_comb begin
		hit_nxt     = hit_q;
		hit_idx_nxt = hit_idx_q;
		rd_val_nxt  = rd_val_q;
		if (state_q == S_SCAN) begin
			if ((op_q == OP_READ) && (step_m == MW'(pos_q))) rd_val_nxt = head;
			if ((op_q == OP_SEARCH) && !hit_q && (step_m < cnt_m) && (head == key_q)) begin
				hit_nxt     = 1'b1;
				hit_idx_nxt = step_q;
			end
		end
	end

	assign scan_last = (state_q == S_SCAN) && (step_q == LAST_STEP);

	// ------------------------------------------------------- result select
	always_comb begin
		load_out     = 1'b0;
		res_status   = ST_OK;
		res_use_data = 1'b0;
		res_data     = rd_val_nxt;
		res_idx      = '0;
		res_count    = count_q;

		if (imm_done) begin
			load_out   = 1'b1;
			res_status = imm_status;
			res_count  = count_nxt;
		end else if ((scan_last || (state_q == S_HOLD)) && out_free) begin
			load_out = 1'b1;
			if (op_q == OP_READ) begin
				res_use_data = 1'b1;
			end else if (hit_nxt) begin
				res_idx = hit_idx_nxt;
			end else begin
				res_status = ST_NOTFOUND;
			end
		end
	end

	assign res_count_m  = MW'(res_count);
	assign res_idx_m    = MW'(res_idx);
	assign res_data_ext = WW'(res_data);

	// ------------------------------------------------------- slot cells
	bla_chain #(
		.DW    (DW),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_chain (
		.clk  (clk),
		.cmd  (cell_cmd),
		.pos  (cell_pos),
		.din  (item_d),
		.head (head)
	);

	// ------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RST;
			inv_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CAPACITY:     cap_q <= cfg_data[CAP_W-1:0];
				REG_INVALID_READ: inv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;

			unique case (state_q)
				S_IDLE: begin
					if (start_scan) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (step_q == LAST_STEP) begin
						step_q  <= '0;
						state_q <= out_free ? S_IDLE : S_HOLD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_HOLD: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			if (load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Request and result payload, no reset needed.
	always_ff @(posedge clk) begin
		hit_idx_q <= hit_idx_nxt;
		rd_val_q  <= rd_val_nxt;
		hit_q     <= start_scan ? 1'b0 : hit_nxt;
		if (start_scan) begin
			op_q  <= in_op;
			pos_q <= in_pos;
			key_q <= item_d;
		end
		if (load_out) begin
			out_status_q <= res_status;
			out_value_q  <= (res_status != ST_OK) ? inv_q :
			                res_use_data ? res_data_ext[ITEM_W-1:0] : '0;
			out_idx_q    <= res_idx_m[POS_W-1:0];
			out_count_q  <= res_count_m[CNT_W-1:0];
			out_full_q   <= (res_count_m >= cap_eff);
			out_empty_q  <= (res_count == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {1'b0, out_empty_q, out_full_q, out_count_q, out_idx_q, out_value_q};

	// ------------------------------------------------------- checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("item count beyond the number of slots");

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SCAN) |-> (step_q == '0))
		else $error("rotation step not at zero outside a scan");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !(out_valid_q && !m_tready))
		else $error("result register written while its item is still waiting");

	a_scan_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (!s_tready && (cell_cmd == CELL_ROT)))
		else $error("request accepted or cells not rotating during a scan");

endmodule
